/* sv/tpce_pkg.sv */
// Package for the passive-open TCP connection engine.
// Holds the item, entry and reply types, flag and state codes and defaults.
// No dependencies.
package tpce_pkg;

   localparam int          DEF_MAX_CONN = 64;
   localparam logic [15:0] DEF_WINDOW   = 16'd14600;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_PSH = 8'h08;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [2:0] CS_CLOSED  = 3'd0;
   localparam logic [2:0] CS_LISTEN  = 3'd1;
   localparam logic [2:0] CS_SYNRCV  = 3'd2;
   localparam logic [2:0] CS_ESTAB   = 3'd3;
   localparam logic [2:0] CS_LASTACK = 3'd4;

   typedef struct packed {
      logic [31:0] initial_seq;
      logic [15:0] tcp_length;
      logic [7:0]  offset_byte;
      logic [7:0]  seg_flags;
      logic [31:0] ack_number;
      logic [31:0] seq_number;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
   } tpce_item_type;

   typedef struct packed {
      logic [2:0]  conn_state;
      logic [31:0] rcv_nxt;
      logic [31:0] snd_nxt;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [31:0] local_ip;
      logic [31:0] remote_ip;
   } tpce_entry_type;

   typedef struct packed {
      logic [15:0] echo_length;
      logic [7:0]  flags;
      logic [31:0] ack;
      logic [31:0] seq;
   } tpce_reply_type;

   typedef struct packed {
      logic [1:0]  pad;
      logic [15:0] echo_length;
      logic [15:0] reply_window;
      logic [7:0]  reply_flags;
      logic [31:0] reply_ack;
      logic [31:0] reply_seq;
      logic [15:0] reply_dest_port;
      logic [15:0] reply_source_port;
      logic [31:0] reply_dst_ip;
      logic [31:0] reply_src_ip;
      logic [5:0]  conn_slot;
   } tpce_rsp_type;

endpackage

/* sv/tpce_table.sv */
// Connection table memory: one write port and one registered read port.
// Depends on tpce_pkg for the entry type.
module tpce_table
   import tpce_pkg::*;
#(
   parameter int MAX_CONN = DEF_MAX_CONN,
   parameter int AW       = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1
) (
   input  logic           clock,
   input  logic [AW-1:0]  rd_addr,
   output tpce_entry_type rd_data,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  tpce_entry_type wr_data
);

   tpce_entry_type mem [MAX_CONN];
   tpce_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tcp_passive_connection_engine_unit.sv */
// Top level of the passive-open TCP connection engine.
// Depends on tpce_pkg and tpce_table.
//
// One parsed TCP segment header enters per item on the req_ channel; the
// checksum flag travels in req_tuser. Reply headers leave on the rsp_ channel,
// zero to three per segment, with rsp_tlast on the last reply of a segment.
// The advertised window is written through csr_wr_en and csr_wr_data; write it
// only while the block is idle, as the block itself does not enforce this.
// A segment with a bad checksum is dropped in the cycle it is taken. Any other
// segment is looked up by reading the connection table one entry a cycle. A
// segment whose tuple is not in the table is compared with every entry, then
// dropped or, for a SYN with a free entry, written in as a new connection;
// a match at entry i ends the scan early. Up to three replies then follow. The
// scan is sequential because the table has a single read port. The next item
// is taken once the last reply has been loaded into the output register.
// Reset clears the valid bits of all entries and the control state, and sets the
// window register to DEF_WINDOW. While the receiver holds rsp_tready low, the
// reply waits in the output register and the block holds back its next reply.
module tcp_passive_connection_engine_unit
   import tpce_pkg::*;
#(
   parameter int MAX_CONNECTIONS = DEF_MAX_CONN
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // src_ip, dst_ip, source_port, dest_port, seq_number, ack_number, seg_flags,
   // offset_byte, tcp_length, initial_seq
   input  logic [223:0] req_tdata,
   // checksum_ok
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // conn_slot, reply_src_ip, reply_dst_ip, reply_source_port, reply_dest_port,
   // reply_seq, reply_ack, reply_flags, reply_window, echo_length, zero pad
   output logic [207:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   localparam int AW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EXEC, ST_EMIT} state_type;

   state_type            state_ff;
   tpce_item_type        item_ff;
   logic [15:0]          win_ff;
   logic [MAX_CONNECTIONS-1:0] valid_ff;
   logic [AW:0]          scan_ff;
   logic                 cmp_vld_ff;
   logic [AW-1:0]        cmp_idx_ff;
   logic                 free_fnd_ff;
   logic [AW-1:0]        free_idx_ff;
   logic [AW-1:0]        slot_ff;
   tpce_entry_type       entry_ff;
   tpce_reply_type       rep_ff [3];
   logic [1:0]           rep_cnt_ff;
   logic [1:0]           rep_idx_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_last_ff;
   tpce_rsp_type         rsp_data_ff;

   tpce_entry_type       rd_data;
   tpce_entry_type       entry_in;
   tpce_reply_type       rep_in [3];
   logic [1:0]           rep_cnt_in;
   logic                 keep_in;
   logic                 match;
   logic                 cur_free;
   logic [15:0]          hlen;
   logic [15:0]          plen;
   logic [31:0]          recv_upd;
   logic                 load;

   tpce_table #(
      .MAX_CONN (MAX_CONNECTIONS),
      .AW       (AW)
   ) u_table (
      .clock   (clock),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (state_ff == ST_EXEC),
      .wr_addr (slot_ff),
      .wr_data (entry_in)
   );

   assign match = cmp_vld_ff && valid_ff[cmp_idx_ff]
                  && rd_data.remote_ip == item_ff.src_ip
                  && rd_data.local_ip == item_ff.dst_ip
                  && rd_data.remote_port == item_ff.source_port
                  && rd_data.local_port == item_ff.dest_port;
   assign cur_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];

   assign hlen     = {10'd0, item_ff.offset_byte[7:2]};
   assign plen     = (item_ff.tcp_length > hlen) ? (item_ff.tcp_length - hlen) : 16'd0;
   assign recv_upd = entry_ff.rcv_nxt + {16'd0, plen};

   always_comb begin
      entry_in   = entry_ff;
      keep_in    = 1'b1;
      rep_cnt_in = 2'd0;
      for (int k = 0; k < 3; k++) begin
         rep_in[k] = '0;
      end
      case (entry_ff.conn_state)
         CS_LISTEN: begin
            if ((item_ff.seg_flags & FL_SYN) != 8'd0) begin
               rep_in[0].seq       = entry_ff.snd_nxt;
               rep_in[0].ack       = item_ff.seq_number + 32'd1;
               rep_in[0].flags     = FL_SYN | FL_ACK;
               rep_cnt_in          = 2'd1;
               entry_in.rcv_nxt    = item_ff.seq_number + 32'd1;
               entry_in.conn_state = CS_SYNRCV;
            end
         end
         CS_SYNRCV: begin
            if ((item_ff.seg_flags & FL_ACK) != 8'd0
                && item_ff.seq_number == entry_ff.rcv_nxt) begin
               entry_in.conn_state = CS_ESTAB;
            end
         end
         CS_ESTAB: begin
            if ((item_ff.seg_flags & FL_FIN) != 8'd0) begin
               rep_in[0].seq       = item_ff.ack_number;
               rep_in[0].ack       = entry_ff.rcv_nxt + 32'd1;
               rep_in[0].flags     = FL_FIN | FL_ACK;
               rep_cnt_in          = 2'd1;
               entry_in.conn_state = CS_LASTACK;
            end
            if ((item_ff.seg_flags & FL_PSH) != 8'd0) begin
               rep_in[rep_cnt_in].seq       = entry_ff.snd_nxt;
               rep_in[rep_cnt_in].ack       = entry_ff.rcv_nxt;
               rep_in[rep_cnt_in].flags     = FL_ACK;
               rep_in[rep_cnt_in + 2'd1].seq         = item_ff.ack_number;
               rep_in[rep_cnt_in + 2'd1].ack         = recv_upd;
               rep_in[rep_cnt_in + 2'd1].flags       = FL_PSH | FL_ACK;
               rep_in[rep_cnt_in + 2'd1].echo_length = plen;
               rep_cnt_in       = rep_cnt_in + 2'd2;
               entry_in.rcv_nxt = recv_upd;
               entry_in.snd_nxt = item_ff.ack_number;
            end
         end
         CS_LASTACK: begin
            if ((item_ff.seg_flags & FL_ACK) != 8'd0
                && item_ff.seq_number == entry_ff.rcv_nxt) begin
               entry_in.conn_state = CS_CLOSED;
               keep_in             = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= DEF_WINDOW;
         valid_ff     <= '0;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         free_fnd_ff  <= 1'b0;
         rep_cnt_ff   <= 2'd0;
         rep_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  item_ff     <= tpce_item_type'(req_tdata);
                  scan_ff     <= '0;
                  cmp_vld_ff  <= 1'b0;
                  free_fnd_ff <= 1'b0;
                  if (req_tuser[0]) begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               cmp_vld_ff <= scan_ff < (AW + 1)'(MAX_CONNECTIONS);
               cmp_idx_ff <= scan_ff[AW-1:0];
               if (scan_ff < (AW + 1)'(MAX_CONNECTIONS)) begin
                  scan_ff <= scan_ff + (AW + 1)'(1);
               end
               if (cur_free && !free_fnd_ff) begin
                  free_fnd_ff <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               if (match) begin
                  entry_ff <= rd_data;
                  slot_ff  <= cmp_idx_ff;
                  state_ff <= ST_EXEC;
               end else if (cmp_vld_ff
                            && cmp_idx_ff == AW'(MAX_CONNECTIONS - 1)) begin
                  if ((item_ff.seg_flags & FL_SYN) != 8'd0
                      && (free_fnd_ff || cur_free)) begin
                     entry_ff.remote_ip   <= item_ff.src_ip;
                     entry_ff.local_ip    <= item_ff.dst_ip;
                     entry_ff.remote_port <= item_ff.source_port;
                     entry_ff.local_port  <= item_ff.dest_port;
                     entry_ff.snd_nxt     <= item_ff.initial_seq;
                     entry_ff.rcv_nxt     <= 32'd0;
                     entry_ff.conn_state  <= CS_LISTEN;
                     slot_ff  <= free_fnd_ff ? free_idx_ff : cmp_idx_ff;
                     state_ff <= ST_EXEC;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_EXEC: begin
               valid_ff[slot_ff] <= keep_in;
               for (int k = 0; k < 3; k++) begin
                  rep_ff[k] <= rep_in[k];
               end
               rep_cnt_ff <= rep_cnt_in;
               rep_idx_ff <= 2'd0;
               state_ff   <= (rep_cnt_in == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
               if (load) begin
                  rsp_last_ff  <= (rep_idx_ff == rep_cnt_ff - 2'd1);
                  rsp_data_ff.pad               <= 2'd0;
                  rsp_data_ff.conn_slot         <= 6'(slot_ff);
                  rsp_data_ff.reply_src_ip      <= item_ff.dst_ip;
                  rsp_data_ff.reply_dst_ip      <= item_ff.src_ip;
                  rsp_data_ff.reply_source_port <= item_ff.dest_port;
                  rsp_data_ff.reply_dest_port   <= item_ff.source_port;
                  rsp_data_ff.reply_seq         <= rep_ff[rep_idx_ff].seq;
                  rsp_data_ff.reply_ack         <= rep_ff[rep_idx_ff].ack;
                  rsp_data_ff.reply_flags       <= rep_ff[rep_idx_ff].flags;
                  rsp_data_ff.reply_window      <= win_ff;
                  rsp_data_ff.echo_length       <= rep_ff[rep_idx_ff].echo_length;
                  rep_idx_ff <= rep_idx_ff + 2'd1;
                  if (rep_idx_ff == rep_cnt_ff - 2'd1) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/tpce_checker.sv */
// Port-level checks for the passive-open TCP connection engine.
// Depends on nothing; bound to tcp_passive_connection_engine_unit below.
module tpce_port_checks (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [207:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Reply item dropped while stalled.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Reply item valid after reset.");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("Item taken while a lookup is running.");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[173:166] == 8'h12 || rsp_tdata[173:166] == 8'h11
                  || rsp_tdata[173:166] == 8'h10 || rsp_tdata[173:166] == 8'h18)
      else $error("Reply item has an unknown flag set.");

   a_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[173:166] != 8'h18 |-> rsp_tdata[205:190] == 16'd0)
      else $error("Control reply item carries an echo length.");

endmodule

bind tcp_passive_connection_engine_unit tpce_port_checks u_tpce_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/tpce_checker.sv */
`timescale 1ns / 100ps
// Checker for the passive-open TCP connection engine: watches the req_, rsp_
// and csr_ channels, predicts the reply headers and compares them in order.
// Depends on tpce_pkg.
module tpce_checker
   import tpce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [223:0] req_tdata,
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [207:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   output int           errors,
   output int           pending
);

   typedef struct {
      tpce_rsp_type hdr;
      logic         last;
   } reply_type;

   reply_type      replies_due[$];
   logic           conn_used [DEF_MAX_CONN];
   tpce_entry_type conn_tab  [DEF_MAX_CONN];
   logic [15:0]    window;

   assign pending = replies_due.size();

   task automatic add_reply(input int slot, input tpce_item_type it, input logic [31:0] seq,
                            input logic [31:0] ack, input logic [7:0] flags,
                            input logic [15:0] elen);
      reply_type r;
      r.hdr = '0;
      r.hdr.conn_slot         = slot[5:0];
      r.hdr.reply_src_ip      = conn_tab[slot].local_ip;
      r.hdr.reply_dst_ip      = conn_tab[slot].remote_ip;
      r.hdr.reply_source_port = it.dest_port;
      r.hdr.reply_dest_port   = it.source_port;
      r.hdr.reply_seq         = seq;
      r.hdr.reply_ack         = ack;
      r.hdr.reply_flags       = flags;
      r.hdr.reply_window      = window;
      r.hdr.echo_length       = elen;
      r.last = 1'b0;
      replies_due.push_back(r);
   endtask

   task automatic predict_segment(input tpce_item_type it, input logic ck);
      int          slot;
      int          n0;
      logic [5:0]  hlen;
      logic [15:0] plen;
      slot = -1;
      n0 = replies_due.size();
      if (!ck) return;
      for (int i = 0; i < DEF_MAX_CONN; i++) begin
         if (slot < 0 && conn_used[i] && conn_tab[i].remote_ip == it.src_ip &&
             conn_tab[i].local_ip == it.dst_ip && conn_tab[i].remote_port == it.source_port &&
             conn_tab[i].local_port == it.dest_port) slot = i;
      end
      if (slot < 0) begin
         if ((it.seg_flags & FL_SYN) == 0) return;
         for (int i = 0; i < DEF_MAX_CONN; i++) begin
            if (slot < 0 && !conn_used[i]) slot = i;
         end
         if (slot < 0) return;
         conn_used[slot] = 1'b1;
         conn_tab[slot].remote_ip   = it.src_ip;
         conn_tab[slot].local_ip    = it.dst_ip;
         conn_tab[slot].remote_port = it.source_port;
         conn_tab[slot].local_port  = it.dest_port;
         conn_tab[slot].snd_nxt     = it.initial_seq;
         conn_tab[slot].rcv_nxt     = '0;
         conn_tab[slot].conn_state  = CS_LISTEN;
      end
      case (conn_tab[slot].conn_state)
         CS_LISTEN: begin
            if (it.seg_flags & FL_SYN) begin
               add_reply(slot, it, conn_tab[slot].snd_nxt, it.seq_number + 32'd1,
                         FL_SYN | FL_ACK, '0);
               conn_tab[slot].rcv_nxt    = it.seq_number + 32'd1;
               conn_tab[slot].conn_state = CS_SYNRCV;
            end
         end
         CS_SYNRCV: begin
            if ((it.seg_flags & FL_ACK) && it.seq_number == conn_tab[slot].rcv_nxt)
               conn_tab[slot].conn_state = CS_ESTAB;
         end
         CS_ESTAB: begin
            if (it.seg_flags & FL_FIN) begin
               add_reply(slot, it, it.ack_number, conn_tab[slot].rcv_nxt + 32'd1,
                         FL_FIN | FL_ACK, '0);
               conn_tab[slot].conn_state = CS_LASTACK;
            end
            if (it.seg_flags & FL_PSH) begin
               hlen = it.offset_byte[7:2];
               plen = (it.tcp_length > hlen) ? it.tcp_length - hlen : '0;
               add_reply(slot, it, conn_tab[slot].snd_nxt, conn_tab[slot].rcv_nxt,
                         FL_ACK, '0);
               conn_tab[slot].rcv_nxt = conn_tab[slot].rcv_nxt + plen;
               conn_tab[slot].snd_nxt = it.ack_number;
               add_reply(slot, it, conn_tab[slot].snd_nxt, conn_tab[slot].rcv_nxt,
                         FL_PSH | FL_ACK, plen);
            end
         end
         CS_LASTACK: begin
            if ((it.seg_flags & FL_ACK) && it.seq_number == conn_tab[slot].rcv_nxt) begin
               conn_tab[slot].conn_state = CS_CLOSED;
               conn_used[slot] = 1'b0;
            end
         end
         default: ;
      endcase
      if (replies_due.size() > n0) replies_due[replies_due.size() - 1].last = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      reply_type    r;
      tpce_rsp_type got;
      if (reset) begin
         window = DEF_WINDOW;
         for (int i = 0; i < DEF_MAX_CONN; i++) conn_used[i] = 1'b0;
      end else begin
         if (csr_wr_en) window = csr_wr_data;
         if (req_tvalid && req_tready) predict_segment(tpce_item_type'(req_tdata), req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            got = tpce_rsp_type'(rsp_tdata);
            if (replies_due.size() == 0) begin
               $error("reply with none expected: slot %0d flags %0h", got.conn_slot,
                      got.reply_flags);
               errors++;
            end else begin
               r = replies_due.pop_front();
               check_field("conn_slot", r.hdr.conn_slot, got.conn_slot);
               check_field("reply_src_ip", r.hdr.reply_src_ip, got.reply_src_ip);
               check_field("reply_dst_ip", r.hdr.reply_dst_ip, got.reply_dst_ip);
               check_field("reply_source_port", r.hdr.reply_source_port,
                           got.reply_source_port);
               check_field("reply_dest_port", r.hdr.reply_dest_port, got.reply_dest_port);
               check_field("reply_seq", r.hdr.reply_seq, got.reply_seq);
               check_field("reply_ack", r.hdr.reply_ack, got.reply_ack);
               check_field("reply_flags", r.hdr.reply_flags, got.reply_flags);
               check_field("reply_window", r.hdr.reply_window, got.reply_window);
               check_field("echo_length", r.hdr.echo_length, got.echo_length);
               check_field("pad", r.hdr.pad, got.pad);
               check_field("last_reply", r.last, rsp_tlast);
            end
         end
      end
   end

endmodule

/* test/tb_tcp_passive_connection_engine_unit.sv */
`timescale 1ns / 100ps
// Testbench top for tcp_passive_connection_engine_unit: drives segments, the
// window register and receiver stalls, and gives the verdict from the checker.
// Depends on tpce_pkg, tpce_checker and the engine RTL.
module tb_tcp_passive_connection_engine_unit;
   import tpce_pkg::*;

   localparam int NUM_CONV  = 8;
   localparam int IDLE_MAX  = 2000;

   typedef struct {
      tpce_item_type tuple;
      int            stage;
      int            left;
      logic [31:0]   rn;
   } conv_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [223:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [207:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wr_en;
   logic [15:0]  csr_wr_data;
   int           errors;
   int           pending;
   logic         quiet;
   int           stall_left;
   int           idle_cycles;
   conv_type     convs [NUM_CONV];

   tcp_passive_connection_engine_unit u_top (.*);

   tpce_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("tb_tcp_passive_connection_engine_unit: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send(input tpce_item_type it, input logic ck);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tdata  <= it;
      req_tuser  <= ck;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_window(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic tpce_item_type make_seg(input tpce_item_type tuple, input logic [7:0] flags,
                                              input logic [31:0] seq, input logic [31:0] ack,
                                              input logic [7:0] offb, input logic [15:0] tlen);
      tpce_item_type it;
      it = tuple;
      it.seg_flags   = flags;
      it.seq_number  = seq;
      it.ack_number  = ack;
      it.offset_byte = offb;
      it.tcp_length  = tlen;
      it.initial_seq = $urandom;
      return it;
   endfunction

   function automatic tpce_item_type rand_tuple();
      tpce_item_type it;
      it = '0;
      it.src_ip      = $urandom;
      it.dst_ip      = $urandom;
      it.source_port = $urandom;
      it.dest_port   = $urandom;
      return it;
   endfunction

   function automatic logic [15:0] rand_length();
      return ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65515))
                                          : 16'($urandom_range(0, 1500));
   endfunction

   function automatic logic [7:0] rand_offset();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h50;
   endfunction

   task automatic conv_step(input int c);
      tpce_item_type it;
      logic [15:0]   tlen;
      logic [7:0]    offb;
      logic [15:0]   plen;
      tlen = rand_length();
      offb = rand_offset();
      plen = (tlen > offb[7:2]) ? tlen - offb[7:2] : '0;
      case (convs[c].stage)
         0: begin
            convs[c].tuple = rand_tuple();
            it = make_seg(convs[c].tuple, FL_SYN | (8'($urandom) & FL_ACK), $urandom,
                          $urandom, offb, tlen);
            convs[c].rn = it.seq_number + 32'd1;
            convs[c].stage = 1;
         end
         1: begin
            it = make_seg(convs[c].tuple, FL_ACK, convs[c].rn, $urandom, offb, tlen);
            convs[c].left = $urandom_range(0, 4);
            convs[c].stage = 2;
         end
         2: begin
            it = make_seg(convs[c].tuple, FL_PSH | FL_ACK, convs[c].rn, $urandom, offb, tlen);
            convs[c].rn = convs[c].rn + plen;
            if (convs[c].left == 0) convs[c].stage = 3;
            else convs[c].left--;
         end
         3: begin
            if ($urandom_range(0, 1)) begin
               it = make_seg(convs[c].tuple, FL_FIN | FL_PSH | FL_ACK, convs[c].rn, $urandom,
                             offb, tlen);
               convs[c].rn = convs[c].rn + plen;
            end else begin
               it = make_seg(convs[c].tuple, FL_FIN | FL_ACK, convs[c].rn, $urandom, offb,
                             tlen);
            end
            convs[c].stage = 4;
         end
         default: begin
            it = make_seg(convs[c].tuple, FL_ACK, convs[c].rn, $urandom, offb, tlen);
            convs[c].stage = 0;
         end
      endcase
      send(it, 1'b1);
   endtask

   task automatic random_phase(input int count);
      tpce_item_type it;
      int            c;
      for (int k = 0; k < count; k++) begin
         c = $urandom_range(0, NUM_CONV - 1);
         case ($urandom_range(0, 19))
            0: begin
               it = make_seg(convs[c].tuple, $urandom, $urandom, $urandom, $urandom,
                             rand_length());
               send(it, 1'b0);
            end
            1: begin
               it = make_seg(rand_tuple(), 8'($urandom) & ~FL_SYN, $urandom, $urandom,
                             $urandom, rand_length());
               send(it, 1'($urandom));
            end
            default: conv_step(c);
         endcase
      end
   endtask

   initial begin
      tpce_item_type ta;
      tpce_item_type tb;
      quiet       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      for (int c = 0; c < NUM_CONV; c++) convs[c].stage = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ta = '0;
      ta.src_ip = 32'h0a000001;    ta.dst_ip = 32'hc0a80001;
      ta.source_port = 16'd40000;  ta.dest_port = 16'd80;
      send(make_seg(ta, FL_SYN, 32'h100, 0, 8'h50, 20), 1'b0);
      send(make_seg(ta, FL_ACK, 32'h100, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_SYN, 32'h100, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_SYN, 32'h100, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_ACK, 32'h200, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_ACK, 32'h101, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_PSH | FL_ACK, 32'h101, 32'h5000, 8'h50, 120), 1'b1);
      send(make_seg(ta, FL_PSH | FL_ACK, 32'h165, 32'hffffffff, 8'hff, 10), 1'b1);
      send(make_seg(ta, FL_PSH | FL_ACK, 32'h165, 32'h0, 8'h00, 16'd65515), 1'b1);
      send(make_seg(ta, FL_PSH | FL_ACK, 32'h165, 32'h1234, 8'hff, 16'd63), 1'b1);
      send(make_seg(ta, 8'h00, 32'h165, 32'h1234, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_FIN | FL_PSH | FL_ACK, 32'h165, 32'h9999, 8'h50, 40), 1'b1);
      send(make_seg(ta, FL_ACK, 32'h0, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_ACK, 32'h10150, 0, 8'h50, 20), 1'b1);
      send(make_seg(ta, FL_ACK, 32'h10150, 0, 8'h50, 20), 1'b1);
      tb = '1;
      send(make_seg(tb, 8'hff, 32'hffffffff, 32'hffffffff, 8'hff, 16'd65515), 1'b1);
      tb = '0;
      send(make_seg(tb, FL_SYN, 32'h0, 32'h0, 8'h00, 16'd0), 1'b1);
      send(make_seg(tb, FL_ACK, 32'h1, 32'h0, 8'h00, 16'd0), 1'b1);
      send(make_seg(tb, FL_FIN | FL_ACK, 32'h1, 32'hffffffff, 8'h00, 16'd0), 1'b1);
      send(make_seg(tb, FL_ACK, 32'h1, 32'h0, 8'h00, 16'd0), 1'b1);

      write_window(16'd0);
      random_phase(150);
      write_window(16'hffff);
      random_phase(150);
      write_window(16'($urandom));
      random_phase(120);
      quiet <= 1'b1;
      write_window(DEF_WINDOW);
      for (int k = 0; k < 70; k++)
         send(make_seg(rand_tuple(), FL_SYN, $urandom, $urandom, 8'h50, 20), 1'b1);
      random_phase(40);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("tb_tcp_passive_connection_engine_unit: done, clean");
      end else begin
         $display("tb_tcp_passive_connection_engine_unit: done, errors");
      end
      $finish;
   end

endmodule
